>>> hdl/rpmd_pkg.sv
// Shared types and constants of the run-length pair marker decoder.
package rpmd_pkg;

  // Longest run a single count byte can describe.
  localparam logic [7:0] MAX_RUN = 8'd255;

  // Width of the decoded-length counter, set by the two-byte header.
  localparam int unsigned REM_W = 16;

  // Decoder phase: which role the next compressed byte plays.
  typedef enum logic [2:0] {
    PH_HDR_HI  = 3'd0,
    PH_HDR_LO  = 3'd1,
    PH_FIRST   = 3'd2,
    PH_LITERAL = 3'd3,
    PH_COUNT   = 3'd4,
    PH_FRESH   = 3'd5
  } phase_t;

  // Architectural decoder state carried from byte to byte.
  typedef struct packed {
    phase_t             phase;
    logic [REM_W-1:0]   remaining;
    logic [7:0]         prev_lit;
    logic [7:0]         hdr_high;
  } dec_state_t;

  // Run descriptor produced by one compressed byte.
  typedef struct packed {
    logic       vld;
    logic [7:0] value;
    logic [7:0] repeat_cnt;
    logic       stream_end;
  } run_res_t;

endpackage

>>> hdl/rpmd_if.sv
// Valid/ready channel interfaces for the compressed input and the run descriptors.
interface rpmd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface rpmd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_value;
  logic [7:0] repeat_res;
  logic       stream_end;

  modport source (output valid, output out_value, output repeat_res, output stream_end,
                  input ready);
  modport sink   (input valid, input out_value, input repeat_res, input stream_end,
                  output ready);
endinterface

>>> hdl/rle_pair_marker_decoder.sv
// A byte passes the input register, then on processing the result register.
// Throughput: one compressed byte per cycle unless the result side stalls; the
// phase and length counter update combinationally, so bytes follow back to back.
// A byte yields zero or one run descriptor; stalls on the result side hold the input.
// Reset (synchronous, active low) returns to awaiting the header high byte with the
// length counter, last literal and stored header byte cleared.
module rle_pair_marker_decoder
  import rpmd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  rpmd_in_if.sink           in_if,
  rpmd_out_if.source        out_if
);

  logic       in_vld_r;
  logic [7:0] in_byte_r;
  dec_state_t st_r;
  dec_state_t st_nxt;
  run_res_t   res;
  logic       out_vld_r;
  logic [7:0] out_value_r;
  logic [7:0] out_rep_r;
  logic       out_end_r;
  logic       out_free;
  logic       proc;

  // The result register can take a new descriptor when empty or being drained.
  assign out_free    = !out_vld_r || out_if.ready;
  assign proc        = in_vld_r && out_free;
  assign in_if.ready = !in_vld_r || out_free;

  // Input register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_if.ready) begin
      in_vld_r <= in_if.valid;
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      in_byte_r <= in_if.in_byte;
    end
  end

  rpmd_step u_step (
    .cur_st  (st_r),
    .byte_in (in_byte_r),
    .nxt_st  (st_nxt),
    .res     (res)
  );

  // Decoder state advances once per processed byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase     <= PH_HDR_HI;
      st_r.remaining <= '0;
      st_r.prev_lit  <= 8'd0;
      st_r.hdr_high  <= 8'd0;
    end else if (proc) begin
      st_r <= st_nxt;
    end
  end

  // Result register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= proc && res.vld;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (proc && res.vld) begin
      out_value_r <= res.value;
      out_rep_r   <= res.repeat_cnt;
      out_end_r   <= res.stream_end;
    end
  end

  assign out_if.valid      = out_vld_r;
  assign out_if.out_value  = out_value_r;
  assign out_if.repeat_res = out_rep_r;
  assign out_if.stream_end = out_end_r;

endmodule

>>> hdl/rpmd_step.sv
// Next-state and run-descriptor logic for one compressed byte.
module rpmd_step
  import rpmd_pkg::*;
(
  input  dec_state_t cur_st,
  input  logic [7:0] byte_in,
  output dec_state_t nxt_st,
  output run_res_t   res
);

  logic [REM_W-1:0] rem_dec;
  logic             lit_end;
  logic [REM_W-1:0] rem_run;
  logic             run_end;
  logic [REM_W-1:0] hdr_len;

  // Literal consumes one decoded byte, saturating at zero.
  assign rem_dec = (cur_st.remaining == '0) ? '0 : cur_st.remaining - REM_W'(1);
  assign lit_end = (rem_dec == '0);

  // A run consumes its count, saturating at zero.
  assign rem_run = ({{(REM_W-8){1'b0}}, byte_in} >= cur_st.remaining) ? '0
                 : cur_st.remaining - {{(REM_W-8){1'b0}}, byte_in};
  assign run_end = (rem_run == '0);

  // Full length once the low header byte arrives.
  assign hdr_len = {cur_st.hdr_high, byte_in};

  // Phase machine for one byte.
  always_comb begin
    nxt_st         = cur_st;
    res.vld        = 1'b0;
    res.value      = 8'd0;
    res.repeat_cnt = 8'd0;
    res.stream_end = 1'b0;
    case (cur_st.phase)
      PH_HDR_LO: begin
        nxt_st.remaining = hdr_len;
        if (hdr_len == '0) begin
          // Empty stream closes with a bare end marker.
          res.vld        = 1'b1;
          res.stream_end = 1'b1;
          nxt_st.phase   = PH_HDR_HI;
        end else begin
          nxt_st.phase = PH_FIRST;
        end
      end
      PH_FIRST, PH_FRESH: begin
        nxt_st.prev_lit  = byte_in;
        nxt_st.remaining = rem_dec;
        res.vld          = 1'b1;
        res.value        = byte_in;
        res.repeat_cnt   = 8'd1;
        res.stream_end   = lit_end;
        nxt_st.phase     = lit_end ? PH_HDR_HI : PH_LITERAL;
      end
      PH_LITERAL: begin
        nxt_st.remaining = rem_dec;
        res.vld          = 1'b1;
        res.value        = byte_in;
        res.repeat_cnt   = 8'd1;
        if (byte_in == cur_st.prev_lit) begin
          // A repeated literal announces a count byte, even past the end.
          nxt_st.phase = PH_COUNT;
        end else begin
          nxt_st.prev_lit = byte_in;
          res.stream_end  = lit_end;
          nxt_st.phase    = lit_end ? PH_HDR_HI : PH_LITERAL;
        end
      end
      PH_COUNT: begin
        nxt_st.remaining = rem_run;
        res.vld          = run_end || (byte_in != 8'd0);
        res.value        = cur_st.prev_lit;
        res.repeat_cnt   = byte_in;
        res.stream_end   = run_end;
        if (run_end) begin
          nxt_st.phase = PH_HDR_HI;
        end else if (byte_in == MAX_RUN) begin
          nxt_st.phase = PH_FRESH;
        end else begin
          nxt_st.phase = PH_LITERAL;
        end
      end
      default: begin
        // High header byte, and any unused phase code.
        nxt_st.hdr_high = byte_in;
        nxt_st.phase    = PH_HDR_LO;
      end
    endcase
  end

endmodule
